@@ hdl/gpt_pkg.sv @@
// ----------------------------------------------------------------------------
// gpt_pkg
// Shared sizes, register map codes and types of the general purpose timer.
// ----------------------------------------------------------------------------
package gpt_pkg;

    // Build-time sizes
    localparam int COUNTER_WIDTH   = 32;   // 16 .. 32
    localparam int PRESCALER_WIDTH = 16;   // 8 .. 32
    localparam int CHANNEL_COUNT   = 4;    // 1 .. 4

    // Fixed field widths of the item
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int PIN_W  = 4;
    localparam int MODE_W = 2;
    localparam int FLAG_W = 5;             // update flag plus one flag per channel slot
    localparam int CCMR_W = 16;
    localparam int CCER_W = 16;
    localparam int CCMR_N = 2;

    // Item kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    // Register map
    localparam logic [ADDR_W-1:0] ADDR_CTRL   = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_EN = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_STATUS = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_EVGEN  = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_CCMR0  = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_CCMR1  = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_CCER   = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_CNT    = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_PSC    = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_ARR    = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_CAP0   = 4'd10;

    // Bit positions
    localparam int CTL_EN_BIT   = 0;
    localparam int CTL_DIR_BIT  = 4;
    localparam int CTL_ARPE_BIT = 7;
    localparam int EVG_UG_BIT   = 0;
    localparam int CCE_EN_BIT   = 0;
    localparam int CCE_P_BIT    = 1;
    localparam int CCE_NP_BIT   = 3;
    localparam int CCE_SLOT_W   = 4;
    localparam int CCM_SLOT_W   = 8;
    localparam int UPD_FLAG_BIT = 0;

    // Capture input select codes
    localparam logic [1:0] SEL_OUTPUT = 2'd0;
    localparam logic [1:0] SEL_OWN    = 2'd1;
    localparam logic [1:0] SEL_PAIR   = 2'd2;

    typedef logic [COUNTER_WIDTH-1:0]   t_cnt;
    typedef logic [PRESCALER_WIDTH-1:0] t_psc;

    typedef struct packed {
        logic en;
        logic down;
        logic arpe;
    } t_ctrl;

    typedef struct packed {
        t_psc prescale_count;
        t_cnt count;
        logic wrap;
    } t_cnt_next;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic              update;
    } t_result;

endpackage

@@ hdl/gpt_capture.sv @@
// ----------------------------------------------------------------------------
// gpt_capture
// Per-channel edge detection on the capture pins, against the pin levels of
// the previous tick.
// ----------------------------------------------------------------------------
module gpt_capture import gpt_pkg::*; (
    input  logic [CCMR_N-1:0][CCMR_W-1:0] i_ccmr,
    input  logic [CCER_W-1:0]             i_ccer,
    input  logic [PIN_W-1:0]              i_last_pins,
    input  logic [PIN_W-1:0]              i_pins,
    output logic [CHANNEL_COUNT-1:0]      o_hit
);

    logic [1:0]            sel;
    logic [CCE_SLOT_W-1:0] ccer;
    logic                  has_src;
    logic                  prev;
    logic                  cur;
    logic                  rise;
    logic                  fall;

    // Edge select per channel: both, falling or rising
    always_comb begin
        sel     = SEL_OUTPUT;
        ccer    = '0;
        has_src = 1'b0;
        prev    = 1'b0;
        cur     = 1'b0;
        rise    = 1'b0;
        fall    = 1'b0;
        o_hit   = '0;
        for (int n = 0; n < CHANNEL_COUNT; n++) begin
            sel     = i_ccmr[n >> 1][(n & 1) * CCM_SLOT_W +: 2];
            ccer    = i_ccer[n * CCE_SLOT_W +: CCE_SLOT_W];
            has_src = 1'b0;
            prev    = 1'b0;
            cur     = 1'b0;
            case (sel)
                SEL_OWN: begin
                    has_src = 1'b1;
                    prev    = i_last_pins[n];
                    cur     = i_pins[n];
                end
                SEL_PAIR: begin
                    // partner channel must exist
                    if ((n ^ 1) < CHANNEL_COUNT) begin
                        has_src = 1'b1;
                        prev    = i_last_pins[n ^ 1];
                        cur     = i_pins[n ^ 1];
                    end
                end
                default: begin
                    has_src = 1'b0;
                end
            endcase
            rise = !prev && cur;
            fall = prev && !cur;
            if (has_src && ccer[CCE_EN_BIT]) begin
                if (ccer[CCE_P_BIT] && ccer[CCE_NP_BIT]) begin
                    o_hit[n] = rise || fall;
                end else if (ccer[CCE_P_BIT]) begin
                    o_hit[n] = fall;
                end else begin
                    o_hit[n] = rise;
                end
            end
        end
    end

endmodule

@@ hdl/gpt_counter.sv @@
// ----------------------------------------------------------------------------
// gpt_counter
// Next prescaler and counter values for one tick, with wrap detection.
// ----------------------------------------------------------------------------
module gpt_counter import gpt_pkg::*; (
    input  t_ctrl     i_ctrl,
    input  t_psc      i_psc_count,
    input  t_psc      i_psc_shadow,
    input  t_cnt      i_count,
    input  t_cnt      i_arr_shadow,
    input  t_cnt      i_arr_preload,
    output t_cnt_next o_next
);

    // Prescale, then step the counter and detect the wrap
    always_comb begin
        o_next.prescale_count = i_psc_count;
        o_next.count          = i_count;
        o_next.wrap           = 1'b0;
        if (i_ctrl.en) begin
            if (i_psc_count < i_psc_shadow) begin
                o_next.prescale_count = i_psc_count + t_psc'(1);
            end else begin
                o_next.prescale_count = '0;
                if (i_ctrl.down) begin
                    if (i_count == '0) begin
                        // reload from the value that the shadow takes now
                        o_next.count = i_arr_preload;
                        o_next.wrap  = 1'b1;
                    end else begin
                        o_next.count = i_count - t_cnt'(1);
                    end
                end else begin
                    if (i_count == i_arr_shadow) begin
                        o_next.count = '0;
                        o_next.wrap  = 1'b1;
                    end else begin
                        o_next.count = i_count + t_cnt'(1);
                    end
                end
            end
        end
    end

endmodule

@@ hdl/gpt_core.sv @@
// ----------------------------------------------------------------------------
// gpt_core
// Timer register file and state; applies one item per enabled cycle and
// gives its result combinationally.
// ----------------------------------------------------------------------------
module gpt_core import gpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ADDR_W-1:0] i_reg_addr,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [PIN_W-1:0]  i_pin_levels,
    output t_result           o_result
);

    t_ctrl                            r_ctrl,    n_ctrl;
    logic [FLAG_W-1:0]                r_irq_en,  n_irq_en;
    logic [FLAG_W-1:0]                r_status,  n_status;
    logic [CCMR_N-1:0][CCMR_W-1:0]    r_ccmr,    n_ccmr;
    logic [CCER_W-1:0]                r_ccer,    n_ccer;
    t_cnt                             r_count,   n_count;
    t_psc                             r_psc_pre, n_psc_pre;
    t_psc                             r_psc_sh,  n_psc_sh;
    t_psc                             r_psc_cnt, n_psc_cnt;
    t_cnt                             r_arr_pre, n_arr_pre;
    t_cnt                             r_arr_sh,  n_arr_sh;
    logic [CHANNEL_COUNT-1:0][COUNTER_WIDTH-1:0] r_cap, n_cap;
    logic [PIN_W-1:0]                 r_last_pins, n_last_pins;

    logic [CHANNEL_COUNT-1:0] hit;
    t_cnt_next                cnt_next;

    gpt_capture u_capture (
        .i_ccmr      (r_ccmr),
        .i_ccer      (r_ccer),
        .i_last_pins (r_last_pins),
        .i_pins      (i_pin_levels),
        .o_hit       (hit)
    );

    gpt_counter u_counter (
        .i_ctrl        (r_ctrl),
        .i_psc_count   (r_psc_cnt),
        .i_psc_shadow  (r_psc_sh),
        .i_count       (r_count),
        .i_arr_shadow  (r_arr_sh),
        .i_arr_preload (r_arr_pre),
        .o_next        (cnt_next)
    );

    // Next state and result for the current item
    always_comb begin
        n_ctrl      = r_ctrl;
        n_irq_en    = r_irq_en;
        n_status    = r_status;
        n_ccmr      = r_ccmr;
        n_ccer      = r_ccer;
        n_count     = r_count;
        n_psc_pre   = r_psc_pre;
        n_psc_sh    = r_psc_sh;
        n_psc_cnt   = r_psc_cnt;
        n_arr_pre   = r_arr_pre;
        n_arr_sh    = r_arr_sh;
        n_cap       = r_cap;
        n_last_pins = r_last_pins;
        o_result    = '0;
        case (i_mode)
            MODE_TICK: begin
                // captures see the count before this tick
                for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                    if (hit[ch]) begin
                        n_cap[ch]        = r_count;
                        n_status[ch + 1] = 1'b1;
                    end
                end
                n_last_pins = i_pin_levels;
                n_psc_cnt   = cnt_next.prescale_count;
                n_count     = cnt_next.count;
                if (cnt_next.wrap) begin
                    n_psc_sh               = r_psc_pre;
                    n_arr_sh               = r_arr_pre;
                    n_status[UPD_FLAG_BIT] = 1'b1;
                    o_result.update        = 1'b1;
                end
            end
            MODE_WRITE: begin
                case (i_reg_addr)
                    ADDR_CTRL: begin
                        n_ctrl.en   = i_write_data[CTL_EN_BIT];
                        n_ctrl.down = i_write_data[CTL_DIR_BIT];
                        n_ctrl.arpe = i_write_data[CTL_ARPE_BIT];
                    end
                    ADDR_IRQ_EN: n_irq_en = i_write_data[FLAG_W-1:0];
                    ADDR_STATUS: n_status = r_status & i_write_data[FLAG_W-1:0];
                    ADDR_EVGEN: begin
                        if (i_write_data[EVG_UG_BIT]) begin
                            n_psc_cnt              = '0;
                            n_psc_sh               = r_psc_pre;
                            n_arr_sh               = r_arr_pre;
                            n_status[UPD_FLAG_BIT] = 1'b1;
                            n_count                = r_ctrl.down ? r_arr_pre : '0;
                            o_result.update        = 1'b1;
                        end
                    end
                    ADDR_CCMR0: n_ccmr[0] = i_write_data[CCMR_W-1:0];
                    ADDR_CCMR1: n_ccmr[1] = i_write_data[CCMR_W-1:0];
                    ADDR_CCER:  n_ccer    = i_write_data[CCER_W-1:0];
                    ADDR_CNT:   n_count   = i_write_data[COUNTER_WIDTH-1:0];
                    ADDR_PSC:   n_psc_pre = i_write_data[PRESCALER_WIDTH-1:0];
                    ADDR_ARR: begin
                        n_arr_pre = i_write_data[COUNTER_WIDTH-1:0];
                        if (!r_ctrl.arpe) begin
                            n_arr_sh = i_write_data[COUNTER_WIDTH-1:0];
                        end
                    end
                    default: begin
                        // capture registers take writes only in output mode
                        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                            if (i_reg_addr == ADDR_CAP0 + ADDR_W'(ch) &&
                                r_ccmr[ch >> 1][(ch & 1) * CCM_SLOT_W +: 2] == SEL_OUTPUT)
                            begin
                                n_cap[ch] = i_write_data[COUNTER_WIDTH-1:0];
                            end
                        end
                    end
                endcase
            end
            MODE_READ: begin
                case (i_reg_addr)
                    ADDR_CTRL: begin
                        o_result.read_data[CTL_EN_BIT]   = r_ctrl.en;
                        o_result.read_data[CTL_DIR_BIT]  = r_ctrl.down;
                        o_result.read_data[CTL_ARPE_BIT] = r_ctrl.arpe;
                    end
                    ADDR_IRQ_EN: o_result.read_data = DATA_W'(r_irq_en);
                    ADDR_STATUS: o_result.read_data = DATA_W'(r_status);
                    ADDR_CCMR0:  o_result.read_data = DATA_W'(r_ccmr[0]);
                    ADDR_CCMR1:  o_result.read_data = DATA_W'(r_ccmr[1]);
                    ADDR_CCER:   o_result.read_data = DATA_W'(r_ccer);
                    ADDR_CNT:    o_result.read_data = DATA_W'(r_count);
                    ADDR_PSC:    o_result.read_data = DATA_W'(r_psc_pre);
                    ADDR_ARR:    o_result.read_data = DATA_W'(r_arr_pre);
                    default: begin
                        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                            if (i_reg_addr == ADDR_CAP0 + ADDR_W'(ch)) begin
                                o_result.read_data = DATA_W'(r_cap[ch]);
                            end
                        end
                    end
                endcase
            end
            default: begin
                o_result.read_data = '0;
            end
        endcase
        o_result.irq = |(n_status & n_irq_en);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl      <= '0;
            r_irq_en    <= '0;
            r_status    <= '0;
            r_ccmr      <= '0;
            r_ccer      <= '0;
            r_count     <= '0;
            r_psc_pre   <= '0;
            r_psc_sh    <= '0;
            r_psc_cnt   <= '0;
            r_arr_pre   <= '1;
            r_arr_sh    <= '1;
            r_cap       <= '0;
            r_last_pins <= '0;
        end else if (i_fire) begin
            r_ctrl      <= n_ctrl;
            r_irq_en    <= n_irq_en;
            r_status    <= n_status;
            r_ccmr      <= n_ccmr;
            r_ccer      <= n_ccer;
            r_count     <= n_count;
            r_psc_pre   <= n_psc_pre;
            r_psc_sh    <= n_psc_sh;
            r_psc_cnt   <= n_psc_cnt;
            r_arr_pre   <= n_arr_pre;
            r_arr_sh    <= n_arr_sh;
            r_cap       <= n_cap;
            r_last_pins <= n_last_pins;
        end
    end

endmodule

@@ hdl/general_purpose_timer_with_capture.sv @@
// ----------------------------------------------------------------------------
// general_purpose_timer_with_capture
// Timer with prescaler, auto-reload and input capture behind a register map.
// ----------------------------------------------------------------------------
// The block takes one item (count tick, register write or register read) per
// clock cycle while the output is not stalled, and returns one result per
// item, in order. An accepted item sits in the input register while the
// register file applies it, and its result is then held in the output
// register. The rate of one item per cycle is set by the single
// register-to-register pass through the register file update; a stalled
// output holds one result while the input register holds the next.
// ----------------------------------------------------------------------------
module general_purpose_timer_with_capture import gpt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ADDR_W-1:0] i_reg_addr,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [PIN_W-1:0]  i_pin_levels,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_irq,
    output logic              o_update_pulse
);

    logic              r_s1_valid;
    logic [MODE_W-1:0] r_mode;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data;
    logic [PIN_W-1:0]  r_pins;
    logic              r_out_valid;
    t_result           r_result;

    logic    advance;
    logic    fire;
    t_result result;

    // Pipeline moves when the output register is free or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_s1_valid && advance;
    assign o_in_ready = !r_s1_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_mode <= i_mode;
            r_addr <= i_reg_addr;
            r_data <= i_write_data;
            r_pins <= i_pin_levels;
        end
    end

    gpt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_mode       (r_mode),
        .i_reg_addr   (r_addr),
        .i_write_data (r_data),
        .i_pin_levels (r_pins),
        .o_result     (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_result.read_data;
    assign o_irq          = r_result.irq;
    assign o_update_pulse = r_result.update;

endmodule

@@ hdl/gpt_checker.sv @@
// ----------------------------------------------------------------------------
// gpt_checker
// Port-level checks of the timer: reset, result ordering and result fields.
// ----------------------------------------------------------------------------
module gpt_checker import gpt_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] o_read_data,
    input logic              o_irq,
    input logic              o_update_pulse
);

    // No result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_data) && $stable(o_irq) &&
            $stable(o_update_pulse))
        else $error("stalled result changed");

    // A fresh result comes from an item that was accepted at the input
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without an accepted item");

    // Updates come from ticks or writes, which return no read data
    a_update_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_update_pulse |-> o_read_data == '0)
        else $error("update result carries read data");

endmodule

bind general_purpose_timer_with_capture gpt_checker u_gpt_checker (.*);
